// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache controller.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned Ways      = 4;
  localparam int unsigned Sets      = 64;
  localparam int unsigned LineBytes = 32;

  localparam int unsigned WayW  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned SetW  = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned OffW  = $clog2(LineBytes);
  localparam int unsigned SetBits = $clog2(Sets);
  localparam int unsigned TagW  = 32 - OffW - SetBits;

  localparam logic [0:0] OpRead  = 1'b0;
  localparam logic [0:0] OpWrite = 1'b1;

  localparam logic [0:0] CfgWriteAllocate = 1'b0;
  localparam logic [0:0] CfgWriteBack     = 1'b1;

  // One way's stored line state.
  typedef struct packed {
    logic            valid;
    logic            dirty;
    logic [TagW-1:0] tag;
    logic [31:0]     last_used;
  } line_t;

  typedef line_t [Ways-1:0] set_line_t;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [31:0] address;
    logic [31:0] wdata;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  way;
    logic        victim_writeback;
    logic [31:0] victim_address;
    logic        fill;
    logic        mem_write;
    logic [31:0] mem_write_address;
    logic [31:0] mem_write_data;
    logic [31:0] hit_count;
  } rsp_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_t;

endpackage

// ===== rtl/salc_if.sv =====
// ----------------------------------------------------------------------------
// salc_if
// Valid/ready channel carrying one payload type.
// ----------------------------------------------------------------------------
interface salc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/set_assoc_lru_cache_controller_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_controller_unit
// Each accepted access reads its set memory row, then updates it in StLook;
// no new access is taken until that read-modify-write is done and the output
// register is free. Reset clears valid bits and counters and sets both config
// bits at once; no clearing sweep. The result sits in an output register.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_controller_unit
  import salc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  salc_if.sink   req_i,
  salc_if.sink   cfg_i,
  salc_if.source rsp_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StLook = 2'b10
  } state_e;

  state_e      state_q, state_d;
  req_t        req_q;
  logic        wa_q, wb_q;
  logic [31:0] clk_q, hits_q;
  logic        out_vld_q;
  rsp_t        out_q;

  set_line_t   rd_set, wr_set;
  logic        upd;
  logic [31:0] clk_n;
  rsp_t        rsp;
  logic        req_fire;
  logic [SetW-1:0] rd_idx, cur_idx;

  assign req_i.ready = (state_q == StIdle) && (!out_vld_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    rd_idx = '0; cur_idx = '0;
    if (SetBits > 0) begin
      rd_idx  = req_i.data.address[OffW +: SetW];
      cur_idx = req_q.address[OffW +: SetW];
    end
  end

  salc_set_ram u_ram (
    .clk_i, .rst_ni,
    .rd_en_i    (req_fire),
    .rd_set_i   (rd_idx),
    .rd_data_o  (rd_set),
    .wr_en_i    (state_q == StLook && upd),
    .wr_set_i   (cur_idx),
    .wr_data_o_i(wr_set)
  );

  salc_policy u_pol (
    .req_i(req_q), .set_i(rd_set),
    .write_allocate_i(wa_q), .write_back_i(wb_q),
    .use_clock_i(clk_q), .hits_i(hits_q),
    .set_o(wr_set), .update_o(upd), .use_clock_o(clk_n), .rsp_o(rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (req_fire) state_d = StLook;
      StLook:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) req_q <= req_i.data;
    if (state_q == StLook) out_q <= rsp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; wa_q <= 1'b1; wb_q <= 1'b1;
      clk_q <= '0; hits_q <= '0; out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          CfgWriteAllocate: wa_q <= cfg_i.data.data[0];
          CfgWriteBack:     wb_q <= cfg_i.data.data[0];
          default: ;
        endcase
      end
      if (state_q == StLook) begin
        clk_q <= clk_n; hits_q <= rsp.hit_count; out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/salc_set_ram.sv =====
// ----------------------------------------------------------------------------
// salc_set_ram
// Per-set line store: one row holds every way; valid bits sit in flops.
// ----------------------------------------------------------------------------
module salc_set_ram
  import salc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [SetW-1:0]   rd_set_i,
  output set_line_t         rd_data_o,
  input  logic              wr_en_i,
  input  logic [SetW-1:0]   wr_set_i,
  input  set_line_t         wr_data_o_i
);

  set_line_t          mem_q [Sets];
  logic [Ways-1:0]    vld_q [Sets];
  set_line_t          rd_q;
  logic [Ways-1:0]    rd_vld_q;

  // Payload array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_set_i] <= wr_data_o_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_set_i];
    end
  end

  // Valid bits cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Sets; s++) vld_q[s] <= '0;
      rd_vld_q <= '0;
    end else begin
      if (wr_en_i) begin
        for (int w = 0; w < Ways; w++) vld_q[wr_set_i][w] <= wr_data_o_i[w].valid;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_set_i];
      end
    end
  end

  always_comb begin
    rd_data_o = rd_q;
    for (int w = 0; w < Ways; w++) begin
      rd_data_o[w].valid = rd_vld_q[w];
      if (!rd_vld_q[w]) rd_data_o[w].dirty = 1'b0;
    end
  end

endmodule

// ===== rtl/salc_policy.sv =====
// ----------------------------------------------------------------------------
// salc_policy
// Hit lookup, LRU victim choice and line update for one access.
// ----------------------------------------------------------------------------
module salc_policy
  import salc_pkg::*;
(
  input  req_t        req_i,
  input  set_line_t   set_i,
  input  logic        write_allocate_i,
  input  logic        write_back_i,
  input  logic [31:0] use_clock_i,
  input  logic [31:0] hits_i,
  output set_line_t   set_o,
  output logic        update_o,
  output logic [31:0] use_clock_o,
  output rsp_t        rsp_o
);

  logic [TagW-1:0] tag;
  logic [SetW-1:0] set_idx;
  logic            is_wr;
  logic            hit;
  logic [WayW-1:0] hit_way, inv_way, lru_way, way;
  logic            any_inv;
  logic [31:0]     least;
  logic [31:0]     clk_n;
  logic [31:0]     va;

  always_comb begin
    tag     = req_i.address[31 -: TagW];
    set_idx = '0;
    if (SetBits > 0) set_idx = req_i.address[OffW +: SetW];
    is_wr   = (req_i.opcode == OpWrite);
    va      = '0;

    // Tag compare, lowest way first
    hit = 1'b0; hit_way = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (set_i[w].valid && set_i[w].tag == tag) begin
        hit = 1'b1; hit_way = WayW'(w);
      end
    end

    // First invalid way, else least timestamp
    any_inv = 1'b0; inv_way = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (!set_i[w].valid) begin
        any_inv = 1'b1; inv_way = WayW'(w);
      end
    end
    least = '1; lru_way = '0;
    for (int w = 0; w < Ways; w++) begin
      if (set_i[w].last_used < least) begin
        least = set_i[w].last_used; lru_way = WayW'(w);
      end
    end

    set_o       = set_i;
    update_o    = 1'b1;
    clk_n       = use_clock_i + 32'd1;
    use_clock_o = use_clock_i;
    rsp_o       = '0;
    rsp_o.hit_count = hits_i + {31'd0, hit};
    rsp_o.hit   = hit;
    way         = hit_way;

    if (!hit) begin
      if (is_wr && !write_allocate_i) begin
        update_o        = 1'b0;
        rsp_o.mem_write = 1'b1;
        way             = '0;
      end else begin
        way = any_inv ? inv_way : lru_way;
        if (set_i[way].valid && set_i[way].dirty) begin
          va = '0;
          va[31 -: TagW] = set_i[way].tag;
          if (SetBits > 0) va[OffW +: SetW] = set_idx;
          rsp_o.victim_writeback = 1'b1;
          rsp_o.victim_address   = va;
        end
        set_o[way].tag   = tag;
        set_o[way].valid = 1'b1;
        set_o[way].dirty = 1'b0;
        rsp_o.fill       = 1'b1;
      end
    end

    if (update_o) begin
      use_clock_o = clk_n;
      set_o[way].last_used = clk_n;
      if (is_wr) begin
        if (write_back_i) set_o[way].dirty = 1'b1;
        else rsp_o.mem_write = 1'b1;
      end
    end

    rsp_o.way = 4'(way);
    if (rsp_o.mem_write) begin
      rsp_o.mem_write_address = req_i.address;
      rsp_o.mem_write_data    = req_i.wdata;
    end
  end

endmodule
